/* rtl/sbs_pkg.sv */
// Shared types, codes and helper functions for the subsystem bring-up sequencer.
package sbs_pkg;

	localparam int unsigned NUM_SUBSYS = 10;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned STATE_W    = 3;
	localparam int unsigned STATES_W   = NUM_SUBSYS * STATE_W;
	localparam int unsigned PHASE_W    = 7;

	typedef logic [IDX_W-1:0]    sub_idx_t;
	typedef logic [STATE_W-1:0]  sub_state_t;
	typedef logic [STATES_W-1:0] states_vec_t;

	// Lifecycle states.
	localparam sub_state_t ST_NONE     = 3'd0;
	localparam sub_state_t ST_INIT     = 3'd1;
	localparam sub_state_t ST_READY    = 3'd2;
	localparam sub_state_t ST_ERROR    = 3'd3;
	localparam sub_state_t ST_SHUTDOWN = 3'd4;

	// Command codes.
	localparam logic [1:0] FN_REQUEST  = 2'd0;
	localparam logic [1:0] FN_CLEAR    = 2'd1;
	localparam logic [1:0] FN_SHUTDOWN = 2'd2;
	localparam logic [1:0] FN_HOOK     = 2'd3;

	// Result status codes.
	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_BAD_INDEX = 3'd1;
	localparam logic [2:0] STS_ILLEGAL   = 3'd2;
	localparam logic [2:0] STS_DEP_WAIT  = 3'd3;
	localparam logic [2:0] STS_NOT_ERROR = 3'd4;

	// Write port of the ready-order memory.
	typedef struct packed {
		logic     en;
		sub_idx_t addr;
		sub_idx_t data;
	} ord_wr_t;

	// Fixed dependency tree.
	function automatic logic has_parent(input sub_idx_t id);
		logic r;
		case (id)
			4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic sub_idx_t parent_of(input sub_idx_t id);
		sub_idx_t r;
		case (id)
			4'd1:    r = 4'd0;
			4'd2:    r = 4'd1;
			4'd4:    r = 4'd3;
			4'd5:    r = 4'd2;
			4'd6:    r = 4'd4;
			4'd7:    r = 4'd5;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic legal_move(input sub_state_t from, input sub_state_t to);
		return (from == ST_NONE     && to == ST_INIT)  ||
		       (from == ST_INIT     && to == ST_READY) ||
		       (from == ST_INIT     && to == ST_ERROR) ||
		       (from == ST_READY    && to == ST_SHUTDOWN) ||
		       (from == ST_SHUTDOWN && to == ST_NONE)  ||
		       (from == ST_ERROR    && to == ST_NONE);
	endfunction

	// State of one subsystem out of the packed vector; indexes past the end read as none.
	function automatic sub_state_t get_state(input states_vec_t v, input sub_idx_t id);
		sub_state_t r;
		r = ST_NONE;
		for (int i = 0; i < NUM_SUBSYS; i++) begin
			if (id == sub_idx_t'(i)) begin
				r = v[i*STATE_W +: STATE_W];
			end
		end
		return r;
	endfunction

	function automatic states_vec_t set_state(input states_vec_t v, input sub_idx_t id,
			input sub_state_t st);
		states_vec_t r;
		r = v;
		for (int i = 0; i < NUM_SUBSYS; i++) begin
			if (id == sub_idx_t'(i)) begin
				r[i*STATE_W +: STATE_W] = st;
			end
		end
		return r;
	endfunction

	// One-hot select of a subsystem; all zero past the end.
	function automatic logic [NUM_SUBSYS-1:0] sub_sel(input sub_idx_t id);
		logic [NUM_SUBSYS-1:0] r;
		r = '0;
		for (int i = 0; i < NUM_SUBSYS; i++) begin
			if (id == sub_idx_t'(i)) begin
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	// Phase gates derived from the packed states.
	function automatic logic [PHASE_W-1:0] phase_mask(input states_vec_t v);
		logic [PHASE_W-1:0] m;
		logic p3;
		logic p5;
		p3 = get_state(v, 4'd6) == ST_READY;
		p5 = get_state(v, 4'd3) == ST_READY && get_state(v, 4'd8) == ST_READY &&
		     get_state(v, 4'd9) == ST_READY;
		m[0] = get_state(v, 4'd0) == ST_READY;
		m[1] = get_state(v, 4'd5) == ST_READY;
		m[2] = get_state(v, 4'd7) == ST_READY;
		m[3] = p3;
		m[4] = p3;
		m[5] = p5;
		m[6] = p5;
		return m;
	endfunction

endpackage

/* rtl/sbs_order_ram.sv */
// Ready-order list storage: one write port, one registered read port.
module sbs_order_ram
	import sbs_pkg::*;
(
	input  logic     clk,
	input  ord_wr_t  wr,
	input  sub_idx_t raddr,
	output sub_idx_t rdata
);

	sub_idx_t mem [NUM_SUBSYS];
	sub_idx_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en && wr.addr < sub_idx_t'(NUM_SUBSYS)) begin
			mem[wr.addr] <= wr.data;
		end
		if (raddr < sub_idx_t'(NUM_SUBSYS)) begin
			rdata_q <= mem[raddr];
		end else begin
			rdata_q <= '0;
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/subsystem_bringup_sequencer.sv */
// Top level of the subsystem bring-up sequencer: lifecycle state, command sequencer, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------------
//  in      | into      | in_valid / in_stall  | func, subsystem, target_state, hook_present
//  out     | out of    | out_valid / out_stall| status, is_shutdown_event, shutdown_subsystem,
//          |           |                      | call_hook, all_states, phase_ready_mask, last
//
// A transition, clear-error or hook command is accepted in idle; the exec state then waits for a
// free output register, applies the update and loads the single result into the output register.
// A shutdown walks the recorded order entries from last to first, reading each from the order memory
// (registered read) in S_SD_ADDR and testing it against the subsystem state in S_SD_CHK.
// Reset clears all lifecycle states, hooks and the order count; the order memory is not cleared.
// The input stalls while a command is in progress. A stalled output register holds the
// sequencer in place, but the next beat may be accepted while the last result still waits.
module subsystem_bringup_sequencer
	import sbs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic [IDX_W-1:0]    subsystem,
	input  logic [STATE_W-1:0]  target_state,
	input  logic                hook_present,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic                is_shutdown_event,
	output logic [IDX_W-1:0]    shutdown_subsystem,
	output logic                call_hook,
	output logic [STATES_W-1:0] all_states,
	output logic [PHASE_W-1:0]  phase_ready_mask,
	output logic                last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SD_ADDR,
		S_SD_CHK,
		S_SD_END
	} seq_state_t;

	seq_state_t state_q;

	// Lifecycle state of all subsystems and their shutdown hooks.
	states_vec_t           states_q;
	logic [NUM_SUBSYS-1:0] hook_q;
	sub_idx_t              count_q;

	// The accepted command.
	logic [1:0] func_q;
	sub_idx_t   sub_q;
	sub_state_t tgt_q;
	logic       hp_q;

	// Shutdown scan: entry index and the event held back until we know whether it is the final one.
	sub_idx_t    idx_q;
	logic        pend_q;
	sub_idx_t    pend_sub_q;
	logic        pend_hook_q;
	states_vec_t pend_states_q;

	// Output register.
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic        event_q;
	sub_idx_t    ev_sub_q;
	logic        ev_hook_q;
	states_vec_t out_states_q;
	logic        last_q;

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// Single-beat command evaluation.
	logic                  id_ok;
	sub_state_t            cur_state;
	logic                  parent_ok;
	logic [NUM_SUBSYS-1:0] sel;
	logic [2:0]            exec_status;
	states_vec_t           exec_states;
	logic [NUM_SUBSYS-1:0] exec_hook;
	logic                  exec_append;

	always_comb begin
		id_ok       = sub_q < sub_idx_t'(NUM_SUBSYS);
		cur_state   = get_state(states_q, sub_q);
		parent_ok   = !has_parent(sub_q) || get_state(states_q, parent_of(sub_q)) == ST_READY;
		sel         = sub_sel(sub_q);
		exec_status = STS_OK;
		exec_states = states_q;
		exec_hook   = hook_q;
		exec_append = 1'b0;
		if (!id_ok) begin
			exec_status = STS_BAD_INDEX;
		end else begin
			case (func_q)
				FN_REQUEST: begin
					if (!legal_move(cur_state, tgt_q)) begin
						exec_status = STS_ILLEGAL;
					end else if (tgt_q == ST_INIT && !parent_ok) begin
						exec_status = STS_DEP_WAIT;
					end else begin
						exec_states = set_state(states_q, sub_q, tgt_q);
						exec_append = tgt_q == ST_READY && count_q < sub_idx_t'(NUM_SUBSYS);
					end
				end
				FN_CLEAR: begin
					if (cur_state != ST_ERROR) begin
						exec_status = STS_NOT_ERROR;
					end else begin
						exec_states = set_state(states_q, sub_q, ST_NONE);
						exec_hook   = hook_q & ~sel;
					end
				end
				FN_HOOK: begin
					exec_hook = hp_q ? (hook_q | sel) : (hook_q & ~sel);
				end
				default: begin
					exec_status = STS_OK;
				end
			endcase
		end
	end

	// Order memory: appended on a successful move to ready, scanned backward on shutdown.
	ord_wr_t  ord_wr;
	sub_idx_t ord_rdata;

	always_comb begin
		ord_wr.en   = state_q == S_EXEC && out_free && exec_append;
		ord_wr.addr = count_q;
		ord_wr.data = sub_q;
	end

	sbs_order_ram u_order (
		.clk   (clk),
		.wr    (ord_wr),
		.raddr (idx_q),
		.rdata (ord_rdata)
	);

	// Shutdown test on the entry just read: the shared state compare of the scan.
	logic                  scan_hit;
	logic [NUM_SUBSYS-1:0] scan_sel;
	states_vec_t           scan_states;

	always_comb begin
		scan_hit    = ord_rdata < sub_idx_t'(NUM_SUBSYS) &&
		              get_state(states_q, ord_rdata) == ST_READY;
		scan_sel    = sub_sel(ord_rdata);
		scan_states = set_state(states_q, ord_rdata, ST_NONE);
	end

	// A new beat enters the output register in this cycle.
	logic out_load;

	always_comb begin
		case (state_q)
			S_EXEC:   out_load = out_free;
			S_SD_CHK: out_load = out_free && scan_hit && pend_q;
			S_SD_END: out_load = out_free;
			default:  out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			states_q    <= '0;
			hook_q      <= '0;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						sub_q  <= subsystem;
						tgt_q  <= target_state;
						hp_q   <= hook_present;
						idx_q  <= count_q - 1'b1;
						if (func != FN_SHUTDOWN) begin
							state_q <= S_EXEC;
						end else if (count_q == '0) begin
							state_q <= S_SD_END;
						end else begin
							state_q <= S_SD_ADDR;
						end
					end
				end
				S_EXEC: begin
					if (out_free) begin
						states_q     <= exec_states;
						hook_q       <= exec_hook;
						if (exec_append) begin
							count_q <= count_q + 1'b1;
						end
						status_q     <= exec_status;
						event_q      <= 1'b0;
						ev_sub_q     <= '0;
						ev_hook_q    <= 1'b0;
						out_states_q <= exec_states;
						last_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_SD_ADDR: begin
					state_q <= S_SD_CHK;
				end
				S_SD_CHK: begin
					// A new hit pushes the held event out, which needs a free output register.
					if (!scan_hit || !pend_q || out_free) begin
						if (scan_hit) begin
							if (pend_q) begin
								status_q     <= STS_OK;
								event_q      <= 1'b1;
								ev_sub_q     <= pend_sub_q;
								ev_hook_q    <= pend_hook_q;
								out_states_q <= pend_states_q;
								last_q       <= 1'b0;
							end
							pend_q        <= 1'b1;
							pend_sub_q    <= ord_rdata;
							pend_hook_q   <= |(hook_q & scan_sel);
							pend_states_q <= scan_states;
							states_q      <= scan_states;
							hook_q        <= hook_q & ~scan_sel;
						end
						if (idx_q == '0) begin
							state_q <= S_SD_END;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= S_SD_ADDR;
						end
					end
				end
				S_SD_END: begin
					if (out_free) begin
						status_q    <= STS_OK;
						last_q      <= 1'b1;
						if (pend_q) begin
							event_q      <= 1'b1;
							ev_sub_q     <= pend_sub_q;
							ev_hook_q    <= pend_hook_q;
							out_states_q <= pend_states_q;
						end else begin
							event_q      <= 1'b0;
							ev_sub_q     <= '0;
							ev_hook_q    <= 1'b0;
							out_states_q <= states_q;
						end
						pend_q  <= 1'b0;
						count_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall           = state_q != S_IDLE;
	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign is_shutdown_event  = event_q;
	assign shutdown_subsystem = ev_sub_q;
	assign call_hook          = ev_hook_q;
	assign all_states         = out_states_q;
	assign phase_ready_mask   = phase_mask(out_states_q);
	assign last               = last_q;

	// The order list never grows past the number of subsystems.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sub_idx_t'(NUM_SUBSYS))
		else $error("ready order count overflow");

	// Shutdown events always carry status ok.
	a_event_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && event_q |-> status_q == STS_OK)
		else $error("shutdown event with bad status");

	// A result that is not an event is the only result of its command.
	a_plain_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !event_q |-> last_q && ev_sub_q == '0 && !ev_hook_q)
		else $error("plain result with event fields set");

	// An accepted beat keeps the input stalled until its work is done.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

endmodule
